[hw/rtl/volume_brightness_key_repeat_assert.svh]
`ifndef VOLUME_BRIGHTNESS_KEY_REPEAT_ASSERT_SVH
`define VOLUME_BRIGHTNESS_KEY_REPEAT_ASSERT_SVH

// check while out of reset
`define VBKR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vbkr assertion failed");

// check through reset as well
`define VBKR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("vbkr reset assertion failed");

`endif

[hw/rtl/vbkr_pkg.sv]
package vbkr_pkg;

    localparam int DEF_LEVEL_WIDTH = 8;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int TOP_W       = 8;
    localparam int MS_W        = 16;
    localparam int CODE_W      = 10;
    localparam int VALUE_W     = 2;
    localparam int OUT_LEVEL_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
    localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_TOP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_WAIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS_CODE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE     = 3'd6;

    localparam logic [TOP_W-1:0]  RST_VOLUME_TOP     = 8'd20;
    localparam logic [TOP_W-1:0]  RST_BRIGHTNESS_TOP = 8'd10;
    localparam logic [MS_W-1:0]   RST_FIRST_WAIT     = 16'd300;
    localparam logic [MS_W-1:0]   RST_STEP_WAIT      = 16'd100;
    localparam logic [CODE_W-1:0] RST_MENU_CODE      = 10'd1;
    localparam logic [CODE_W-1:0] RST_PLUS_CODE      = 10'd115;
    localparam logic [CODE_W-1:0] RST_MINUS_CODE     = 10'd114;

    typedef struct packed {
        logic [TOP_W-1:0]  volume_top;
        logic [TOP_W-1:0]  brightness_top;
        logic [MS_W-1:0]   first_wait;
        logic [MS_W-1:0]   step_wait;
        logic [CODE_W-1:0] menu_code;
        logic [CODE_W-1:0] plus_code;
        logic [CODE_W-1:0] minus_code;
    } t_cfg;

    typedef struct packed {
        logic               operation;
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] key_value;
    } t_item;

    typedef struct packed {
        logic [OUT_LEVEL_W-1:0] volume_level;
        logic [OUT_LEVEL_W-1:0] brightness_level;
        logic                   level_changed;
    } t_result;

endpackage

[hw/rtl/vbkr_cfg.sv]
module vbkr_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [vbkr_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [vbkr_pkg::CFG_DATA_W-1:0]    i_data,
    output vbkr_pkg::t_cfg                     o_cfg
);
    import vbkr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_top      <= RST_VOLUME_TOP;
            r_cfg.brightness_top  <= RST_BRIGHTNESS_TOP;
            r_cfg.first_wait      <= RST_FIRST_WAIT;
            r_cfg.step_wait       <= RST_STEP_WAIT;
            r_cfg.menu_code       <= RST_MENU_CODE;
            r_cfg.plus_code       <= RST_PLUS_CODE;
            r_cfg.minus_code      <= RST_MINUS_CODE;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_VOLUME_TOP:     r_cfg.volume_top      <= i_data[TOP_W-1:0];
                CFG_BRIGHTNESS_TOP: r_cfg.brightness_top  <= i_data[TOP_W-1:0];
                CFG_FIRST_WAIT:     r_cfg.first_wait      <= i_data[MS_W-1:0];
                CFG_STEP_WAIT:      r_cfg.step_wait       <= i_data[MS_W-1:0];
                CFG_MENU_CODE:      r_cfg.menu_code       <= i_data[CODE_W-1:0];
                CFG_PLUS_CODE:      r_cfg.plus_code       <= i_data[CODE_W-1:0];
                CFG_MINUS_CODE:     r_cfg.minus_code      <= i_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/vbkr_state.sv]
module vbkr_state #(
    parameter int LEVEL_WIDTH = vbkr_pkg::DEF_LEVEL_WIDTH,
    parameter int COUNT_WIDTH = vbkr_pkg::DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  vbkr_pkg::t_item    i_item,
    input  vbkr_pkg::t_cfg     i_cfg,
    output vbkr_pkg::t_result  o_result
);
    import vbkr_pkg::*;

    localparam int CW = ((LEVEL_WIDTH > TOP_W) ? LEVEL_WIDTH : TOP_W) + 1;

    function automatic logic [LEVEL_WIDTH-1:0] f_step(
        input logic                   up,
        input logic [LEVEL_WIDTH-1:0] old,
        input logic [CW-1:0]          top
    );
        logic [CW-1:0] v;
        v = CW'(old);
        if (up) begin
            v = v + CW'(1);
        end else if (v != '0) begin
            v = v - CW'(1);
        end
        if (v > top) begin
            v = top;
        end
        return LEVEL_WIDTH'(v);
    endfunction

    logic                   r_menu_held, n_menu_held;
    logic                   r_plus_held, n_plus_held;
    logic                   r_minus_held, n_minus_held;
    logic [COUNT_WIDTH-1:0] r_plus_cnt, n_plus_cnt;
    logic [COUNT_WIDTH-1:0] r_minus_cnt, n_minus_cnt;
    logic [LEVEL_WIDTH-1:0] r_volume, n_volume;
    logic [LEVEL_WIDTH-1:0] r_brightness, n_brightness;

    logic                   up_go, dn_go, press, changed;
    logic [CW-1:0]          top_raw, top_lim, top_sel;
    logic [LEVEL_WIDTH-1:0] lvl0, lvl1, lvl2;

    always_comb begin
        n_menu_held  = r_menu_held;
        n_plus_held  = r_plus_held;
        n_minus_held = r_minus_held;
        n_plus_cnt   = r_plus_cnt;
        n_minus_cnt  = r_minus_cnt;
        n_volume     = r_volume;
        n_brightness = r_brightness;
        up_go        = 1'b0;
        dn_go        = 1'b0;
        press        = (i_item.key_value == KEY_PRESS);

        if (i_item.operation == OP_TICK) begin
            if (r_plus_held) begin
                if (r_plus_cnt <= COUNT_WIDTH'(1)) begin
                    n_plus_cnt = COUNT_WIDTH'(i_cfg.step_wait);
                    up_go      = 1'b1;
                end else begin
                    n_plus_cnt = r_plus_cnt - COUNT_WIDTH'(1);
                end
            end
            if (r_minus_held) begin
                if (r_minus_cnt <= COUNT_WIDTH'(1)) begin
                    n_minus_cnt = COUNT_WIDTH'(i_cfg.step_wait);
                    dn_go       = 1'b1;
                end else begin
                    n_minus_cnt = r_minus_cnt - COUNT_WIDTH'(1);
                end
            end
        end else if (i_item.key_value == KEY_RELEASE || i_item.key_value == KEY_PRESS) begin
            priority if (i_item.key_code == i_cfg.menu_code) begin
                n_menu_held = press;
            end else if (i_item.key_code == i_cfg.plus_code) begin
                n_plus_held = press;
                if (press) begin
                    up_go      = 1'b1;
                    n_plus_cnt = COUNT_WIDTH'(i_cfg.first_wait);
                end
            end else if (i_item.key_code == i_cfg.minus_code) begin
                n_minus_held = press;
                if (press) begin
                    dn_go       = 1'b1;
                    n_minus_cnt = COUNT_WIDTH'(i_cfg.first_wait);
                end
            end
        end

        // plus step first, then minus, on the level picked by menu
        top_raw = CW'(r_menu_held ? i_cfg.brightness_top : i_cfg.volume_top);
        top_lim = CW'({LEVEL_WIDTH{1'b1}});
        top_sel = (top_raw > top_lim) ? top_lim : top_raw;
        lvl0    = r_menu_held ? r_brightness : r_volume;
        lvl1    = up_go ? f_step(1'b1, lvl0, top_sel) : lvl0;
        lvl2    = dn_go ? f_step(1'b0, lvl1, top_sel) : lvl1;
        changed = (lvl1 != lvl0) || (lvl2 != lvl1);
        if (r_menu_held) begin
            n_brightness = lvl2;
        end else begin
            n_volume = lvl2;
        end

        o_result.volume_level     = OUT_LEVEL_W'(n_volume);
        o_result.brightness_level = OUT_LEVEL_W'(n_brightness);
        o_result.level_changed    = changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu_held  <= 1'b0;
            r_plus_held  <= 1'b0;
            r_minus_held <= 1'b0;
            r_plus_cnt   <= '0;
            r_minus_cnt  <= '0;
            r_volume     <= '0;
            r_brightness <= '0;
        end else if (i_fire) begin
            r_menu_held  <= n_menu_held;
            r_plus_held  <= n_plus_held;
            r_minus_held <= n_minus_held;
            r_plus_cnt   <= n_plus_cnt;
            r_minus_cnt  <= n_minus_cnt;
            r_volume     <= n_volume;
            r_brightness <= n_brightness;
        end
    end

endmodule

[hw/rtl/volume_brightness_key_repeat.sv]
// channel   dir  handshake                   payload
// s         in   i_s_tvalid / o_s_tready     tuser: operation; tdata: key_code, key_value
// m         out  o_m_tvalid / i_m_tready     tdata: volume_level, brightness_level,
//                                            level_changed
// cfg       in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word per cycle in and out while m is not stalled; an accepted word loads the input
// register, and the result register loads from it when m can advance, which raises
// o_m_tvalid (the held-key and level update sits between the two registers).
// Reset (i_rst_n low, synchronous) clears both valid flags, the held keys, countdowns,
// levels and restores the configuration defaults.
// A stall on m holds the result register; s keeps taking words until the input
// register also fills. Configuration writes are taken in every cycle.
module volume_brightness_key_repeat #(
    parameter int LEVEL_WIDTH = vbkr_pkg::DEF_LEVEL_WIDTH,
    parameter int COUNT_WIDTH = vbkr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [9:0] key_code, [11:10] key_value
    input  logic [vbkr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [0] operation
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] volume_level, [15:8] brightness_level, [16] level_changed
    output logic [vbkr_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vbkr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vbkr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vbkr_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_item   r_in_item;
    t_result r_out_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    fire;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_m_tready;
    assign fire        = r_in_valid && advance;
    assign o_s_tready  = !r_in_valid || advance;

    vbkr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    vbkr_state #(
        .LEVEL_WIDTH (LEVEL_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.operation <= i_s_tuser;
            r_in_item.key_code  <= i_s_tdata[CODE_W-1:0];
            r_in_item.key_value <= i_s_tdata[CODE_W+VALUE_W-1:CODE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_result <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_result.level_changed,
                                      r_out_result.brightness_level,
                                      r_out_result.volume_level});

endmodule

[hw/rtl/vbkr_checker.sv]
`include "volume_brightness_key_repeat_assert.svh"

module vbkr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [vbkr_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import vbkr_pkg::*;

    logic                     out_acc;
    logic                     r_have;
    logic [2*OUT_LEVEL_W-1:0] r_last_lvl;
    logic [2*OUT_LEVEL_W-1:0] cur_lvl;
    logic                     cur_chg;

    assign out_acc = o_m_tvalid && i_m_tready;
    assign cur_lvl = o_m_tdata[2*OUT_LEVEL_W-1:0];
    assign cur_chg = o_m_tdata[2*OUT_LEVEL_W];

    // levels after reset are zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b1;
            r_last_lvl <= '0;
        end else if (out_acc) begin
            r_have     <= 1'b1;
            r_last_lvl <= cur_lvl;
        end
    end

    `VBKR_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_tvalid)
    `VBKR_ASSERT(a_hold_valid, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `VBKR_ASSERT(a_free_input, !o_m_tvalid |-> o_s_tready)
    `VBKR_ASSERT(a_no_change, out_acc && r_have && !cur_chg |-> cur_lvl == r_last_lvl)

endmodule

bind volume_brightness_key_repeat vbkr_checker u_vbkr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
